// ----- hdl/overlap_add_reconstruction_assert.svh -----
// Assertion macros shared by the overlap-add checker.
// Depends on nothing; include by bare file name.
`ifndef OVERLAP_ADD_RECONSTRUCTION_ASSERT_SVH
`define OVERLAP_ADD_RECONSTRUCTION_ASSERT_SVH

// Same-cycle implication, abandoned while rst is high.
`define OAR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("overlap-add assertion failed");

// Next-cycle implication, abandoned while rst is high.
`define OAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("overlap-add assertion failed");

`endif

// ----- hdl/oar_pkg.sv -----
// Shared constants and types for the overlap-add reconstruction block.
// No dependencies; the top, queue, front and back files and the testbench refer to it by scoped names.
package oar_pkg;

   localparam int FRAME_LEN_BITS = 11;
   localparam int OVERLAP_BITS   = 10;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;
   localparam int QUEUE_DEPTH    = 4;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_LEN = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OVERLAP   = 2'd1;

   localparam logic [FRAME_LEN_BITS-1:0] FRAME_LEN_RESET = 11'd256;
   localparam logic [FRAME_LEN_BITS-1:0] FRAME_LEN_MIN   = 11'd2;
   localparam logic [OVERLAP_BITS-1:0]   OVERLAP_RESET   = 10'd0;

   // what the back end does with one sample
   typedef struct packed {
      logic is_tail;   // store into tail memory, no output
      logic add_tail;  // add stored tail entry before output
      logic hop_done;  // last output of the frame
   } cmd_type;

endpackage

// ----- hdl/overlap_add_reconstruction.sv -----
// Overlap-add reconstruction. Takes framed samples on req_ and returns the
// rebuilt stream on rsp_, hop = frame_len - overlap outputs per frame; the
// last overlap samples of a frame are held in a single-port tail memory of
// MAX_FRAME/2 words and added to the head of the next frame. Sustained rate
// is one sample per cycle while rsp_ is not stalled, set by the one
// tail-memory access each sample needs. Samples pass the queue, the read
// stage and the output register. The tail memory is not cleared after reset
// and needs no start-up pass. Write frame_len and overlap only while no
// samples are in flight; overlap is clamped to half a frame.
module overlap_add_reconstruction #(
   parameter int MAX_FRAME   = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // csr write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [oar_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [oar_pkg::CSR_DATA_BITS-1:0]   csr_data,
   // sample input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // sample
   input  logic                                req_tlast,  // stream_end
   // reconstructed output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+8)/8)*8-1:0]    rsp_tdata,  // value
   output logic                                rsp_tlast   // hop_done
);

   localparam int AW            = $clog2(MAX_FRAME / 2);
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 8) / 8) * 8;
   localparam int CMDW          = $bits(oar_pkg::cmd_type);
   localparam int QW            = CMDW + AW + SAMPLE_BITS;

   logic                        push, full, pop, not_empty;
   oar_pkg::cmd_type            push_cmd, pop_cmd;
   logic [AW-1:0]               push_addr, pop_addr;
   logic [SAMPLE_BITS-1:0]      push_sample, pop_sample;
   logic [QW-1:0]               push_data, pop_data;
   logic signed [SAMPLE_BITS:0] rsp_value;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;

   oar_front #(
      .MAX_FRAME   (MAX_FRAME),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_sample   (req_tdata[SAMPLE_BITS-1:0]),
      .in_last     (req_tlast),
      .push        (push),
      .push_cmd    (push_cmd),
      .push_addr   (push_addr),
      .push_sample (push_sample)
   );

   assign push_data = {push_cmd, push_addr, push_sample};

   oar_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   assign pop_cmd    = pop_data[QW-1 -: CMDW];
   assign pop_addr   = pop_data[SAMPLE_BITS +: AW];
   assign pop_sample = pop_data[SAMPLE_BITS-1:0];

   oar_back #(
      .MAX_FRAME   (MAX_FRAME),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (not_empty),
      .q_cmd     (pop_cmd),
      .q_addr    (pop_addr),
      .q_sample  (pop_sample),
      .q_pop     (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_value),
      .out_done  (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_BITS'($unsigned(rsp_value));

endmodule

// ----- hdl/oar_queue.sv -----
// Short register FIFO between the front and back ends.
// Depends on oar_pkg for its depth.
module oar_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int DEPTH = oar_pkg::QUEUE_DEPTH;
   localparam int PTRW  = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTRW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTRW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/oar_front.sv -----
// Front end: configuration registers, frame position tracking and sample
// classification into head, middle or tail. Depends on oar_pkg.
module oar_front #(
   parameter int MAX_FRAME   = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [oar_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [oar_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 in_valid,
   input  logic                                 in_ready,
   input  logic [SAMPLE_BITS-1:0]               in_sample,
   input  logic                                 in_last,
   output logic                                 push,
   output oar_pkg::cmd_type                     push_cmd,
   output logic [$clog2(MAX_FRAME/2)-1:0]       push_addr,
   output logic [SAMPLE_BITS-1:0]               push_sample
);

   localparam int LW = $clog2(MAX_FRAME + 1);
   localparam int PW = $clog2(MAX_FRAME);
   localparam int AW = $clog2(MAX_FRAME / 2);
   localparam int CW = (LW > oar_pkg::FRAME_LEN_BITS) ? LW : oar_pkg::FRAME_LEN_BITS;
   localparam logic [CW-1:0] MAX_LEN = CW'(MAX_FRAME);

   logic [oar_pkg::FRAME_LEN_BITS-1:0] frame_len_ff;
   logic [oar_pkg::OVERLAP_BITS-1:0]   overlap_ff;
   logic [PW-1:0]                      pos_ff, pos_in;
   logic                               first_ff, first_in;

   logic [CW-1:0] len_wide, half_wide, ov_wide;
   logic [LW-1:0] len, ov, hop, pos, pos_next, tail_idx;
   logic          is_head, is_mid;

   always_comb begin
      len_wide = CW'(frame_len_ff);
      if (len_wide < CW'(oar_pkg::FRAME_LEN_MIN)) begin
         len_wide = CW'(oar_pkg::FRAME_LEN_MIN);
      end else if (len_wide > MAX_LEN) begin
         len_wide = MAX_LEN;
      end
      len       = len_wide[LW-1:0];
      half_wide = CW'(len >> 1);
      ov_wide   = CW'(overlap_ff);
      if (ov_wide > half_wide) begin
         ov_wide = half_wide;
      end
      ov  = ov_wide[LW-1:0];
      hop = len - ov;

      // a shortened frame may leave the position past its end
      pos = LW'(pos_ff);
      if (pos >= len) begin
         pos = '0;
      end
      is_head  = (pos < ov);
      is_mid   = !is_head && (pos < hop);
      tail_idx = pos - hop;

      push_cmd.is_tail  = !(is_head || is_mid);
      push_cmd.add_tail = is_head && !first_ff;
      push_cmd.hop_done = (pos == hop - LW'(1));
      push_addr         = is_head ? pos[AW-1:0] : tail_idx[AW-1:0];
      push_sample       = in_sample;
      push              = in_valid && in_ready;

      pos_next = pos + LW'(1);
      first_in = first_ff;
      if (pos_next >= len) begin
         pos_next = '0;
         first_in = 1'b0;
      end
      if (in_last) begin
         pos_next = '0;
         first_in = 1'b1;
      end
      pos_in = pos_next[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= oar_pkg::FRAME_LEN_RESET;
         overlap_ff   <= oar_pkg::OVERLAP_RESET;
         pos_ff       <= '0;
         first_ff     <= 1'b1;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               oar_pkg::REG_FRAME_LEN: begin
                  frame_len_ff <= csr_data[oar_pkg::FRAME_LEN_BITS-1:0];
               end
               oar_pkg::REG_OVERLAP: begin
                  overlap_ff <= csr_data[oar_pkg::OVERLAP_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (push) begin
            pos_ff   <= pos_in;
            first_ff <= first_in;
         end
      end
   end

endmodule

// ----- hdl/oar_back.sv -----
// Back end: tail memory access, overlap addition and the output register.
// Depends on oar_pkg for the command type.
module oar_back #(
   parameter int MAX_FRAME   = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  oar_pkg::cmd_type                   q_cmd,
   input  logic [$clog2(MAX_FRAME/2)-1:0]     q_addr,
   input  logic [SAMPLE_BITS-1:0]             q_sample,
   output logic                               q_pop,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [SAMPLE_BITS:0]        out_value,
   output logic                               out_done
);

   localparam int TAIL_DEPTH = MAX_FRAME / 2;

   logic [SAMPLE_BITS-1:0] tail_mem [TAIL_DEPTH];

   // read stage
   logic                   a_valid_ff;
   logic [SAMPLE_BITS-1:0] a_sample_ff;
   logic [SAMPLE_BITS-1:0] a_tail_ff;
   logic                   a_add_ff;
   logic                   a_done_ff;

   // output register
   logic                      o_valid_ff;
   logic signed [SAMPLE_BITS:0] o_value_ff, o_value_in;
   logic                      o_done_ff;

   logic o_free, a_free, a_load;
   logic signed [SAMPLE_BITS:0] addend;

   assign o_free = !o_valid_ff || out_ready;
   assign a_free = !a_valid_ff || o_free;
   assign q_pop  = q_valid && (q_cmd.is_tail || a_free);
   assign a_load = q_pop && !q_cmd.is_tail;

   always_comb begin
      addend     = a_add_ff ? (SAMPLE_BITS+1)'(signed'(a_tail_ff)) : '0;
      o_value_in = (SAMPLE_BITS+1)'(signed'(a_sample_ff)) + addend;
   end

   assign out_valid = o_valid_ff;
   assign out_value = o_value_ff;
   assign out_done  = o_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_load) begin
            a_valid_ff <= 1'b1;
         end else if (o_free) begin
            a_valid_ff <= 1'b0;
         end
         if (o_free) begin
            o_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_sample_ff <= q_sample;
         a_tail_ff   <= tail_mem[q_addr];
         a_add_ff    <= q_cmd.add_tail;
         a_done_ff   <= q_cmd.hop_done;
      end
      if (o_free) begin
         o_value_ff <= o_value_in;
         o_done_ff  <= a_done_ff;
      end
   end

   // hold the tail of the current frame for the next one
   always_ff @(posedge clock) begin
      if (q_pop && q_cmd.is_tail) begin
         tail_mem[q_addr] <= q_sample;
      end
   end

endmodule

// ----- hdl/oar_checker.sv -----
// Port-level checks for the overlap-add block, attached by bind.
// Depends on overlap_add_reconstruction_assert.svh.
`include "overlap_add_reconstruction_assert.svh"

module oar_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((SAMPLE_BITS+8)/8)*8-1:0]     rsp_tdata,
   input logic                                 rsp_tlast
);

   // a stalled result holds until its transfer
   `OAR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // a result only leaves through a transfer or a reset
   `OAR_ASSERT_NOW(a_rsp_drop, clock, reset, $fell(rsp_tvalid) && !$past(reset), $past(rsp_tready))

   // reset empties the queue and the output stages
   `OAR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready)

endmodule

bind overlap_add_reconstruction oar_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_oar_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/overlap_add_reconstruction_tb.sv -----
// Self-checking testbench for overlap_add_reconstruction: a directed table, then
// random framed streams under several frame and overlap settings, all checked in order.
// Depends on oar_pkg and the overlap_add_reconstruction RTL only.
module overlap_add_reconstruction_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAME     = 1024;
   localparam int SAMPLE_BITS   = 24;
   localparam int PERIOD        = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 1450;

   // index with no register behind it; writes must change nothing
   localparam logic [oar_pkg::CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;

   typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_VALUE} exp_kind_type;
   typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_HICCUP} rx_mode_type;

   typedef struct packed {
      exp_kind_type       kind;
      logic signed [24:0] val;
      logic               done;
   } exp_note_type;

   typedef struct {
      row_kind_type                       kind;
      logic [oar_pkg::CSR_INDEX_BITS-1:0] idx;
      logic [oar_pkg::CSR_DATA_BITS-1:0]  data;
      logic signed [23:0]                 smp;
      bit                                 last;
      exp_note_type                       note;
   } step_row_type;

   localparam exp_note_type PREDICTED = '{EXP_PREDICT, 25'sd0, 1'b0};

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [oar_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [oar_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [23:0]                        req_tdata = '0;   // sample
   logic                               req_tlast = 1'b0; // stream_end
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [31:0]                        rsp_tdata;        // value, zero filled above bit 24
   logic                               rsp_tlast;        // hop_done
   exp_note_type                       req_note = PREDICTED;

   // predictor state
   logic [oar_pkg::FRAME_LEN_BITS-1:0] cfg_frame_len = oar_pkg::FRAME_LEN_RESET;
   logic [oar_pkg::OVERLAP_BITS-1:0]   cfg_overlap = oar_pkg::OVERLAP_RESET;
   logic signed [23:0]                 tail_mem [MAX_FRAME/2];
   int unsigned                        frame_pos = 0;
   bit                                 first_frame = 1'b1;

   exp_note_type pending_outputs[$];
   int           mismatch_count = 0;
   int           burst_left = 0;
   int           idle_cycles = 0;
   rx_mode_type  rx_mode = RX_STEADY;
   int           rx_mode_left = 0;

   overlap_add_reconstruction #(
      .MAX_FRAME  (MAX_FRAME),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #(PERIOD/2) clock = ~clock;

   // Advance the predictor by one accepted sample; returns 1 when it yields an output.
   function automatic bit rebuild_sample(input logic signed [23:0] s, input bit last,
                                         output logic signed [24:0] val, output logic done);
      int unsigned len, ov, hop, pos;
      bit produced;
      len = 32'(cfg_frame_len);
      if (len < 2) len = 2;
      if (len > MAX_FRAME) len = MAX_FRAME;
      ov = 32'(cfg_overlap);
      if (ov > len / 2) ov = len / 2;
      hop = len - ov;
      pos = frame_pos;
      if (pos >= len) pos = 0;
      produced = 1'b0;
      val = 25'(s);
      done = 1'b0;
      if (pos < ov) begin
         produced = 1'b1;
         if (!first_frame) val = 25'(s) + 25'(tail_mem[pos]);
      end else if (pos < hop) begin
         produced = 1'b1;
      end else begin
         tail_mem[pos - hop] = s;
      end
      if (produced && pos == hop - 1) done = 1'b1;
      pos++;
      if (pos >= len) begin
         pos = 0;
         first_frame = 1'b0;
      end
      frame_pos = pos;
      if (last) begin
         frame_pos = 0;
         first_frame = 1'b1;
      end
      return produced;
   endfunction

   function automatic step_row_type write_row(input logic [oar_pkg::CSR_INDEX_BITS-1:0] idx,
                                              input logic [oar_pkg::CSR_DATA_BITS-1:0] data);
      step_row_type r;
      r = '{ROW_WRITE, idx, data, 24'sd0, 1'b0, PREDICTED};
      return r;
   endfunction

   function automatic step_row_type sample_row(input logic signed [23:0] s, input bit last);
      step_row_type r;
      r = '{ROW_SAMPLE, '0, '0, s, last, PREDICTED};
      return r;
   endfunction

   function automatic step_row_type result_row(input logic signed [23:0] s, input bit last,
                                               input logic signed [24:0] val,
                                               input logic done);
      step_row_type r;
      r = '{ROW_SAMPLE, '0, '0, s, last, exp_note_type'{EXP_VALUE, val, done}};
      return r;
   endfunction

   function automatic step_row_type silent_row(input logic signed [23:0] s, input bit last);
      step_row_type r;
      r = '{ROW_SAMPLE, '0, '0, s, last, exp_note_type'{EXP_NONE, 25'sd0, 1'b0}};
      return r;
   endfunction

   function automatic logic signed [23:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Leaves req_tvalid high so the next sample can follow without a bubble.
   task automatic push_sample(input logic signed [23:0] s, input bit last,
                              input exp_note_type note);
      int gap;
      csr_valid <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= last;
      req_note   <= note;
      do @(posedge clock); while (!req_tready);
   endtask

   // Leaves csr_valid high; the next sample or drain lowers it.
   task automatic write_reg(input logic [oar_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [oar_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         oar_pkg::REG_FRAME_LEN: cfg_frame_len = data;
         oar_pkg::REG_OVERLAP:   cfg_overlap = data[oar_pkg::OVERLAP_BITS-1:0];
         default: ;
      endcase
   endtask

   // Hold the sender until every expected output is back, then let tail writes settle.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      do @(negedge clock); while (pending_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Predict on each accepted sample, then check each accepted output.
   always @(posedge clock) begin : scoreboard
      logic signed [24:0] val;
      logic               done;
      logic signed [24:0] got_val;
      exp_note_type       want;
      bit                 some;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            some = rebuild_sample($signed(req_tdata), req_tlast, val, done);
            case (req_note.kind)
               EXP_VALUE: pending_outputs.push_back(req_note);
               EXP_NONE: ;
               default: if (some) pending_outputs.push_back(exp_note_type'{EXP_VALUE, val, done});
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got_val = $signed(rsp_tdata[24:0]);
            if (pending_outputs.size() == 0) begin
               report_mismatch($sformatf("output %0d with none expected", got_val));
            end else begin
               want = pending_outputs.pop_front();
               if (got_val !== want.val)
                  report_mismatch($sformatf("value %0d, expected %0d", got_val, want.val));
               if (rsp_tlast !== want.done)
                  report_mismatch($sformatf("hop_done %b, expected %b (value %0d)",
                                            rsp_tlast, want.done, want.val));
            end
         end
      end
   end

   // Receiver back-pressure: switch at random between stall patterns.
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= rx_mode_type'($urandom_range(0, 3));
         rx_mode_left <= $urandom_range(50, 300);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         RX_STEADY: rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:   rsp_tready <= ($urandom_range(0, 15) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      step_row_type steps[$];
      int random_items, phase, pick, raw_len, eff_len, raw_ov, n_send;
      bit big;

      // reset setting: 256-sample frames, no overlap, stream ends at once
      steps.push_back(result_row(24'sh123456, 1'b1, 25'sh0123456, 1'b0));
      // four-sample frames, two shared: full-scale heads and tails
      steps.push_back(write_row(oar_pkg::REG_FRAME_LEN, 11'd4));
      steps.push_back(write_row(oar_pkg::REG_OVERLAP, 11'd2));
      steps.push_back(result_row(24'sh7FFFFF, 1'b0, 25'sd8388607, 1'b0));
      steps.push_back(result_row(24'sh800000, 1'b0, -25'sd8388608, 1'b1));
      steps.push_back(silent_row(24'sh7FFFFF, 1'b0));
      steps.push_back(silent_row(24'sh800000, 1'b0));
      steps.push_back(result_row(24'sh7FFFFF, 1'b0, 25'sd16777214, 1'b0));
      steps.push_back(result_row(24'sh800000, 1'b0, 25'sh1000000, 1'b1)); // most negative sum
      steps.push_back(silent_row(24'sh7FFFFF, 1'b0));
      steps.push_back(silent_row(24'sh800000, 1'b0));
      steps.push_back(result_row(24'sd0, 1'b0, 25'sd8388607, 1'b0));
      steps.push_back(result_row(-24'sd1, 1'b0, -25'sd8388609, 1'b1));
      steps.push_back(silent_row(24'sd1, 1'b0));
      steps.push_back(silent_row(24'sd0, 1'b1));
      // back to first-frame pass-through; stream cut inside the tail region
      steps.push_back(result_row(-24'sd1, 1'b0, -25'sd1, 1'b0));
      steps.push_back(result_row(24'sd0, 1'b0, 25'sd0, 1'b1));
      steps.push_back(silent_row(24'sd3, 1'b1));
      // frame length zero counts as two, overlap clamps to one
      steps.push_back(write_row(oar_pkg::REG_FRAME_LEN, 11'd0));
      steps.push_back(write_row(oar_pkg::REG_OVERLAP, 11'd1023));
      steps.push_back(result_row(24'sd100, 1'b0, 25'sd100, 1'b1));
      steps.push_back(silent_row(24'sd200, 1'b0));
      steps.push_back(result_row(24'sd7, 1'b0, 25'sd207, 1'b1));
      steps.push_back(silent_row(24'sd9, 1'b1));
      steps.push_back(write_row(REG_SPARE, 11'h7FF));
      // shrink the frame under a part-filled first frame: restart at position zero
      steps.push_back(write_row(oar_pkg::REG_FRAME_LEN, 11'd4));
      steps.push_back(write_row(oar_pkg::REG_OVERLAP, 11'd0));
      steps.push_back(sample_row(24'sd5, 1'b0));
      steps.push_back(sample_row(24'sd6, 1'b0));
      steps.push_back(sample_row(24'sd7, 1'b0));
      steps.push_back(write_row(oar_pkg::REG_FRAME_LEN, 11'd2));
      steps.push_back(sample_row(24'sd8, 1'b0));
      steps.push_back(sample_row(24'sd9, 1'b1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[k]) begin
         if (steps[k].kind == ROW_WRITE) begin
            drain_pipeline();
            write_reg(steps[k].idx, steps[k].data);
         end else begin
            push_sample(steps[k].smp, steps[k].last, steps[k].note);
         end
      end

      // Each phase starts in first-frame state and ends on a stream end, so the
      // head of a frame only ever reads tail entries written under the same setting.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         big = (phase == 4);
         pick = $urandom_range(0, 9);
         if (big)           raw_len = $urandom_range(MAX_FRAME, 2047);
         else if (pick < 7) raw_len = $urandom_range(2, 24);
         else if (pick < 9) raw_len = $urandom_range(25, 120);
         else               raw_len = $urandom_range(0, 3);
         eff_len = (raw_len < 2) ? 2 : (raw_len > MAX_FRAME) ? MAX_FRAME : raw_len;
         pick = $urandom_range(0, 4);
         if (pick < 3)       raw_ov = $urandom_range(0, eff_len / 2);
         else if (pick == 3) raw_ov = eff_len / 2 + $urandom_range(0, 1);
         else                raw_ov = $urandom_range(0, 1023);

         drain_pipeline();
         if (!big && eff_len <= 24 && $urandom_range(0, 5) == 0) begin
            // part of a longer first frame, so the new length lands past the position
            write_reg(oar_pkg::REG_FRAME_LEN,
                      oar_pkg::CSR_DATA_BITS'(eff_len + $urandom_range(1, 16)));
            n_send = $urandom_range(eff_len, int'(cfg_frame_len) - 1);
            repeat (n_send) push_sample(random_sample(), 1'b0, PREDICTED);
            random_items += n_send;
            drain_pipeline();
         end
         write_reg(oar_pkg::REG_FRAME_LEN, oar_pkg::CSR_DATA_BITS'(raw_len));
         write_reg(oar_pkg::REG_OVERLAP, oar_pkg::CSR_DATA_BITS'(raw_ov));

         if (big) begin
            n_send = eff_len + $urandom_range(1, 24);
         end else begin
            n_send = eff_len * $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) n_send += $urandom_range(1, eff_len - 1);
            // trim the final phase so the total lands near the target
            if (n_send > RANDOM_ITEMS - random_items) n_send = RANDOM_ITEMS - random_items;
         end
         for (int i = 0; i < n_send; i++)
            push_sample(random_sample(), i == n_send - 1, PREDICTED);
         if (n_send > 0) random_items += n_send;
      end

      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
